// File: rtl/tccw_pkg.sv
package tccw_pkg;

   localparam int OP_W     = 3;
   localparam int CHAR_W   = 8;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int COLOR_W  = 4;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = 16;
   localparam int POS_W    = 11;
   localparam int TAB_STEP = 8;

   localparam logic [OP_W-1:0] OP_STREAM = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_CURSOR = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_COLOR = 8'd13;

   typedef enum logic [2:0] {
      SWEEP_NONE,
      SWEEP_INIT,
      SWEEP_CLEAR,
      SWEEP_COPY,
      SWEEP_FILL
   } sweep_mode_type;

   typedef struct packed {
      logic           load;
      logic           exec;
      logic           respond;
      logic           resp_read;
      logic           sweep_load;
      logic           sweep_to_fill;
      sweep_mode_type sweep_mode;
   } dp_cmd_type;

   typedef struct packed {
      logic op_read;
      logic op_clear;
      logic need_scroll;
      logic sweep_done;
   } dp_status_type;

endpackage

// File: rtl/tccw_ctrl.sv
module tccw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tccw_pkg::dp_status_type status,
   output tccw_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_CLEAR
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in           = state_ff;
      cmd.load           = 1'b0;
      cmd.exec           = 1'b0;
      cmd.respond        = 1'b0;
      cmd.resp_read      = 1'b0;
      cmd.sweep_load     = 1'b0;
      cmd.sweep_to_fill  = 1'b0;
      cmd.sweep_mode     = tccw_pkg::SWEEP_NONE;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_mode = tccw_pkg::SWEEP_INIT;
            if (status.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.op_read) begin
               state_in = ST_READ;
            end else if (status.op_clear) begin
               cmd.sweep_load = 1'b1;
               state_in       = ST_CLEAR;
            end else if (status.need_scroll) begin
               cmd.sweep_load = 1'b1;
               state_in       = ST_COPY;
            end else begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.respond   = 1'b1;
            cmd.resp_read = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_COPY: begin
            cmd.sweep_mode = tccw_pkg::SWEEP_COPY;
            if (status.sweep_done) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.sweep_load    = 1'b1;
            cmd.sweep_to_fill = 1'b1;
            state_in          = ST_FILL;
         end
         ST_FILL: begin
            cmd.sweep_mode = tccw_pkg::SWEEP_FILL;
            if (status.sweep_done) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.sweep_mode = tccw_pkg::SWEEP_CLEAR;
            if (status.sweep_done) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/tccw_datapath.sv
module tccw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tccw_pkg::dp_cmd_type                cmd,
   output tccw_pkg::dp_status_type             status,
   input  logic [tccw_pkg::OP_W-1:0]           req_operation,
   input  logic [tccw_pkg::CHAR_W-1:0]         req_character,
   input  logic [tccw_pkg::ROW_W-1:0]          req_row,
   input  logic [tccw_pkg::COL_W-1:0]          req_column,
   input  logic [tccw_pkg::COLOR_W-1:0]        req_foreground,
   input  logic [tccw_pkg::COLOR_W-1:0]        req_background,
   input  logic                                csr_write,
   input  logic [tccw_pkg::ATTR_W-1:0]         csr_wdata,
   output logic                                rsp_valid,
   output logic [tccw_pkg::CELL_W-1:0]         rsp_cell_value,
   output logic [tccw_pkg::ROW_W-1:0]          rsp_cursor_row_out,
   output logic [tccw_pkg::COL_W-1:0]          rsp_cursor_column_out,
   output logic [tccw_pkg::POS_W-1:0]          rsp_cursor_position
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] FILL_BASE = ADDR_W'(CELLS - COLUMNS);

   logic [tccw_pkg::OP_W-1:0]    op_ff;
   logic [tccw_pkg::CHAR_W-1:0]  char_ff;
   logic [tccw_pkg::ROW_W-1:0]   row_ff;
   logic [tccw_pkg::COL_W-1:0]   col_ff;
   logic [tccw_pkg::COLOR_W-1:0] fg_ff;
   logic [tccw_pkg::COLOR_W-1:0] bg_ff;

   logic [tccw_pkg::ATTR_W-1:0]  text_color_ff;
   logic [tccw_pkg::ROW_W-1:0]   cur_line_ff, cur_line_in;
   logic [tccw_pkg::COL_W-1:0]   cur_column_ff, cur_column_in;
   logic [ADDR_W-1:0]            sweep_ff, sweep_in;
   logic                         copy_valid_ff;
   logic [ADDR_W-1:0]            copy_addr_ff;
   logic [tccw_pkg::CELL_W-1:0]  rdata_ff;
   logic                         rsp_valid_ff;
   logic [tccw_pkg::CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;

   logic [tccw_pkg::CELL_W-1:0]  screen_ff [CELLS];

   logic                         req_inside;
   logic [ADDR_W-1:0]            req_addr;
   logic [ADDR_W-1:0]            cursor_addr;
   logic [tccw_pkg::CELL_W-1:0]  blank;
   logic [tccw_pkg::COL_W:0]     col_ext, col_step;
   logic [tccw_pkg::ROW_W:0]     line_step;
   logic                         need_scroll;
   logic [tccw_pkg::ROW_W-1:0]   stream_row;
   logic [tccw_pkg::COL_W-1:0]   stream_col;
   logic                         we;
   logic [ADDR_W-1:0]            waddr;
   logic [tccw_pkg::CELL_W-1:0]  wdata;
   logic [ADDR_W-1:0]            raddr;
   logic                         sweep_done;

   assign req_inside  = (row_ff < ROWS) && (col_ff < COLUMNS);
   assign req_addr    = req_inside ? ADDR_W'(row_ff * COLUMNS + col_ff) : '0;
   assign cursor_addr = ADDR_W'(cur_line_ff * COLUMNS + cur_column_ff);
   assign blank       = {text_color_ff, tccw_pkg::CHAR_BLANK};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         char_ff <= req_character;
         row_ff  <= req_row;
         col_ff  <= req_column;
         fg_ff   <= req_foreground;
         bg_ff   <= req_background;
      end
   end

   // stream cursor advance
   always_comb begin
      col_ext   = {1'b0, cur_column_ff};
      col_step  = col_ext;
      line_step = {1'b0, cur_line_ff};
      case (char_ff)
         tccw_pkg::CHAR_NEWLINE: begin
            col_step  = '0;
            line_step = line_step + 1'b1;
         end
         tccw_pkg::CHAR_RETURN: begin
            col_step = '0;
         end
         tccw_pkg::CHAR_BACKSPACE: begin
            if (cur_column_ff != '0) col_step = col_ext - 1'b1;
         end
         tccw_pkg::CHAR_TAB: begin
            col_step = (col_ext + (tccw_pkg::COL_W+1)'(tccw_pkg::TAB_STEP))
                       & ~(tccw_pkg::COL_W+1)'(tccw_pkg::TAB_STEP - 1);
         end
         default: begin
            col_step = col_ext + 1'b1;
         end
      endcase
      if (col_step >= COLUMNS) begin
         col_step  = '0;
         line_step = line_step + 1'b1;
      end
      need_scroll = (line_step >= ROWS);
      stream_row  = need_scroll ? tccw_pkg::ROW_W'(ROWS - 1)
                                : line_step[tccw_pkg::ROW_W-1:0];
      stream_col  = col_step[tccw_pkg::COL_W-1:0];
   end

   always_comb begin
      cur_line_in   = cur_line_ff;
      cur_column_in = cur_column_ff;
      if (cmd.exec) begin
         case (op_ff)
            tccw_pkg::OP_STREAM: begin
               cur_line_in   = stream_row;
               cur_column_in = stream_col;
            end
            tccw_pkg::OP_CURSOR: begin
               cur_line_in   = (row_ff >= ROWS) ? tccw_pkg::ROW_W'(ROWS - 1) : row_ff;
               cur_column_in = (col_ff >= COLUMNS) ? tccw_pkg::COL_W'(COLUMNS - 1) : col_ff;
            end
            tccw_pkg::OP_CLEAR: begin
               cur_line_in   = '0;
               cur_column_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // write port
   always_comb begin
      we    = 1'b0;
      waddr = cursor_addr;
      wdata = blank;
      if (copy_valid_ff) begin
         we    = 1'b1;
         waddr = copy_addr_ff;
         wdata = rdata_ff;
      end else begin
         case (cmd.sweep_mode)
            tccw_pkg::SWEEP_INIT: begin
               we    = 1'b1;
               waddr = sweep_ff;
               wdata = {tccw_pkg::RESET_COLOR, tccw_pkg::CHAR_BLANK};
            end
            tccw_pkg::SWEEP_CLEAR, tccw_pkg::SWEEP_FILL: begin
               we    = 1'b1;
               waddr = sweep_ff;
            end
            default: begin
               if (cmd.exec && op_ff == tccw_pkg::OP_STREAM) begin
                  case (char_ff)
                     tccw_pkg::CHAR_NEWLINE, tccw_pkg::CHAR_RETURN, tccw_pkg::CHAR_TAB: begin
                     end
                     tccw_pkg::CHAR_BACKSPACE: begin
                        if (cur_column_ff != '0) begin
                           we    = 1'b1;
                           waddr = cursor_addr - ADDR_W'(1);
                        end
                     end
                     default: begin
                        we    = 1'b1;
                        wdata = {text_color_ff, char_ff};
                     end
                  endcase
               end else if (cmd.exec && op_ff == tccw_pkg::OP_WRITE && req_inside) begin
                  we    = 1'b1;
                  waddr = req_addr;
                  wdata = {bg_ff, fg_ff, char_ff};
               end
            end
         endcase
      end
   end

   assign raddr = (cmd.sweep_mode == tccw_pkg::SWEEP_COPY) ? ADDR_W'(sweep_ff + COLUMNS)
                                                         : req_addr;

   always_ff @(posedge clock) begin
      if (we) screen_ff[waddr] <= wdata;
      rdata_ff <= screen_ff[raddr];
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_load) begin
         sweep_in = cmd.sweep_to_fill ? FILL_BASE : '0;
      end else if (cmd.sweep_mode != tccw_pkg::SWEEP_NONE) begin
         sweep_in = sweep_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      case (cmd.sweep_mode)
         tccw_pkg::SWEEP_COPY: sweep_done = (sweep_ff == COPY_LAST);
         tccw_pkg::SWEEP_INIT, tccw_pkg::SWEEP_CLEAR, tccw_pkg::SWEEP_FILL:
            sweep_done = (sweep_ff == LAST_CELL);
         default: sweep_done = 1'b0;
      endcase
   end

   assign status = '{
      op_read:     (op_ff == tccw_pkg::OP_READ),
      op_clear:    (op_ff == tccw_pkg::OP_CLEAR),
      need_scroll: (op_ff == tccw_pkg::OP_STREAM) && need_scroll,
      sweep_done:  sweep_done
   };

   always_comb begin
      rsp_cell_in = rsp_cell_ff;
      if (cmd.respond) begin
         if (cmd.resp_read) rsp_cell_in = req_inside ? rdata_ff : blank;
         else rsp_cell_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= tccw_pkg::RESET_COLOR;
         cur_line_ff   <= '0;
         cur_column_ff <= '0;
         sweep_ff      <= '0;
         copy_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) text_color_ff <= csr_wdata;
         cur_line_ff   <= cur_line_in;
         cur_column_ff <= cur_column_in;
         sweep_ff      <= sweep_in;
         copy_valid_ff <= (cmd.sweep_mode == tccw_pkg::SWEEP_COPY);
         rsp_valid_ff  <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= sweep_ff;
      rsp_cell_ff  <= rsp_cell_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cell_value        = rsp_cell_ff;
   assign rsp_cursor_row_out    = cur_line_ff;
   assign rsp_cursor_column_out = cur_column_ff;
   assign rsp_cursor_position   = tccw_pkg::POS_W'(cur_line_ff * COLUMNS + cur_column_ff);

`ifndef SYNTHESIS
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cur_line_ff < ROWS) && (cur_column_ff < COLUMNS))
      else $error("cursor outside screen at response");

   a_copy_write_alone: assert property (@(posedge clock) disable iff (reset)
      copy_valid_ff |-> !cmd.exec && (cmd.sweep_mode == tccw_pkg::SWEEP_COPY
                                      || cmd.sweep_mode == tccw_pkg::SWEEP_NONE))
      else $error("scroll copy write collides with another write");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held longer than one cycle");
`endif

endmodule

// File: rtl/text_console_character_writer.sv
// A stream without scroll, a cell write, a cursor set or an unused code responds from the
// execute state; a cell read first passes a registered screen memory read; a clear sweeps
// every cell; a stream that scrolls copies each row up (one copy per cycle), then blanks the bottom row.
// A new request is not accepted until the previous one is done and busy is low; the
// result strobe overlaps the next accept, and the receiver cannot stall.
// Reset: synchronous; a clearing pass over every cell holds busy high afterwards.
module text_console_character_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tccw_pkg::OP_W-1:0]     req_operation,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_character,
   input  logic [tccw_pkg::ROW_W-1:0]    req_row,
   input  logic [tccw_pkg::COL_W-1:0]    req_column,
   input  logic [tccw_pkg::COLOR_W-1:0]  req_foreground,
   input  logic [tccw_pkg::COLOR_W-1:0]  req_background,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tccw_pkg::ATTR_W-1:0]   csr_wdata,
   output logic                          rsp_valid,
   output logic [tccw_pkg::CELL_W-1:0]   rsp_cell_value,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_cursor_row_out,
   output logic [tccw_pkg::COL_W-1:0]    rsp_cursor_column_out,
   output logic [tccw_pkg::POS_W-1:0]    rsp_cursor_position
);

   tccw_pkg::dp_cmd_type    cmd;
   tccw_pkg::dp_status_type status;
   logic                    ctrl_busy;

   assign csr_ready = 1'b1;
   assign busy      = ctrl_busy;

   tccw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (ctrl_busy),
      .status (status),
      .cmd    (cmd)
   );

   tccw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_operation         (req_operation),
      .req_character         (req_character),
      .req_row               (req_row),
      .req_column            (req_column),
      .req_foreground        (req_foreground),
      .req_background        (req_background),
      .csr_write             (csr_valid & csr_ready),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_cell_value        (rsp_cell_value),
      .rsp_cursor_row_out    (rsp_cursor_row_out),
      .rsp_cursor_column_out (rsp_cursor_column_out),
      .rsp_cursor_position   (rsp_cursor_position)
   );

endmodule

// File: dv/text_console_checker.sv
module text_console_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [tccw_pkg::OP_W-1:0]     req_operation,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_character,
   input  logic [tccw_pkg::ROW_W-1:0]    req_row,
   input  logic [tccw_pkg::COL_W-1:0]    req_column,
   input  logic [tccw_pkg::COLOR_W-1:0]  req_foreground,
   input  logic [tccw_pkg::COLOR_W-1:0]  req_background,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [tccw_pkg::ATTR_W-1:0]   csr_wdata,
   input  logic                          rsp_valid,
   input  logic [tccw_pkg::CELL_W-1:0]   rsp_cell_value,
   input  logic [tccw_pkg::ROW_W-1:0]    rsp_cursor_row_out,
   input  logic [tccw_pkg::COL_W-1:0]    rsp_cursor_column_out,
   input  logic [tccw_pkg::POS_W-1:0]    rsp_cursor_position,
   output int                            fail_count,
   output int                            open_count
);

   localparam int CELLS = ROWS * COLUMNS;

   typedef struct packed {
      logic [tccw_pkg::CELL_W-1:0] cell_value;
      logic [tccw_pkg::ROW_W-1:0]  row;
      logic [tccw_pkg::COL_W-1:0]  column;
      logic [tccw_pkg::POS_W-1:0]  position;
   } console_report_type;

   logic [tccw_pkg::CELL_W-1:0] screen_model [CELLS];
   int unsigned                 cur_line;
   int unsigned                 cur_column;
   logic [tccw_pkg::ATTR_W-1:0] text_color;
   console_report_type          pending_reports [$];
   console_report_type          wanted;
   console_report_type          seen;
   int                          mismatches = 0;

   function automatic logic [tccw_pkg::CELL_W-1:0] blank_cell();
      return {text_color, tccw_pkg::CHAR_BLANK};
   endfunction

   task automatic blank_screen();
      for (int i = 0; i < CELLS; i++) begin
         screen_model[i] = blank_cell();
      end
   endtask

   task automatic apply_console_request(
      input  logic [tccw_pkg::OP_W-1:0]    op,
      input  logic [tccw_pkg::CHAR_W-1:0]  ch,
      input  logic [tccw_pkg::ROW_W-1:0]   row,
      input  logic [tccw_pkg::COL_W-1:0]   col,
      input  logic [tccw_pkg::COLOR_W-1:0] fg,
      input  logic [tccw_pkg::COLOR_W-1:0] bg,
      output console_report_type           report
   );
      logic [tccw_pkg::CELL_W-1:0] value;
      logic                        on_screen;
      value     = '0;
      on_screen = (row < ROWS) && (col < COLUMNS);
      case (op)
         tccw_pkg::OP_STREAM: begin
            if (ch == tccw_pkg::CHAR_BACKSPACE) begin
               if (cur_column > 0) begin
                  cur_column--;
                  screen_model[cur_line * COLUMNS + cur_column] = blank_cell();
               end
            end else begin
               case (ch)
                  tccw_pkg::CHAR_NEWLINE: begin
                     cur_column = 0;
                     cur_line++;
                  end
                  tccw_pkg::CHAR_RETURN: cur_column = 0;
                  tccw_pkg::CHAR_TAB: begin
                     cur_column = (cur_column + tccw_pkg::TAB_STEP) / tccw_pkg::TAB_STEP
                                  * tccw_pkg::TAB_STEP;
                  end
                  default: begin
                     screen_model[cur_line * COLUMNS + cur_column] = {text_color, ch};
                     cur_column++;
                  end
               endcase
               if (cur_column >= COLUMNS) begin
                  cur_column = 0;
                  cur_line++;
               end
               if (cur_line >= ROWS) begin
                  for (int i = 0; i + COLUMNS < CELLS; i++) begin
                     screen_model[i] = screen_model[i + COLUMNS];
                  end
                  for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                     screen_model[i] = blank_cell();
                  end
                  cur_line--;
               end
            end
         end
         tccw_pkg::OP_WRITE: begin
            if (on_screen) begin
               screen_model[row * COLUMNS + col] = {bg, fg, ch};
            end
         end
         tccw_pkg::OP_READ: begin
            value = on_screen ? screen_model[row * COLUMNS + col] : blank_cell();
         end
         tccw_pkg::OP_CURSOR: begin
            cur_line   = (row >= ROWS) ? ROWS - 1 : row;
            cur_column = (col >= COLUMNS) ? COLUMNS - 1 : col;
         end
         tccw_pkg::OP_CLEAR: begin
            blank_screen();
            cur_line   = 0;
            cur_column = 0;
         end
         default: begin
         end
      endcase
      report.cell_value = value;
      report.row        = tccw_pkg::ROW_W'(cur_line);
      report.column     = tccw_pkg::COL_W'(cur_column);
      report.position   = tccw_pkg::POS_W'(cur_line * COLUMNS + cur_column);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         text_color = tccw_pkg::RESET_COLOR;
         cur_line   = 0;
         cur_column = 0;
         blank_screen();
         pending_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            text_color = csr_wdata;
         end
         if (rsp_valid) begin
            seen = '{rsp_cell_value, rsp_cursor_row_out, rsp_cursor_column_out,
                     rsp_cursor_position};
            if (pending_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected response: cell %h row %0d col %0d pos %0d",
                           seen.cell_value, seen.row, seen.column, seen.position);
               end
            end else begin
               wanted = pending_reports.pop_front();
               if (seen.cell_value !== wanted.cell_value || seen.row !== wanted.row ||
                   seen.column !== wanted.column || seen.position !== wanted.position) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response mismatch: expected cell %h row %0d col %0d pos %0d",
                              wanted.cell_value, wanted.row, wanted.column, wanted.position);
                     $display("                   actual   cell %h row %0d col %0d pos %0d",
                              seen.cell_value, seen.row, seen.column, seen.position);
                  end
               end
            end
         end
         if (start && !busy) begin
            apply_console_request(req_operation, req_character, req_row, req_column,
                                  req_foreground, req_background, wanted);
            pending_reports.push_back(wanted);
         end
      end
      fail_count <= mismatches;
      open_count <= pending_reports.size();
   end

endmodule

// File: dv/tb_text_console_character_writer.sv
module tb_text_console_character_writer;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int RUN_LIMIT     = 10_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 360;

   localparam logic [tccw_pkg::OP_W-1:0] OP_SPARE_FIRST = tccw_pkg::OP_CLEAR + 3'd1;
   localparam logic [tccw_pkg::OP_W-1:0] OP_SPARE_LAST  = '1;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          start          = 1'b0;
   logic                          busy;
   logic [tccw_pkg::OP_W-1:0]     req_operation  = '0;
   logic [tccw_pkg::CHAR_W-1:0]   req_character  = '0;
   logic [tccw_pkg::ROW_W-1:0]    req_row        = '0;
   logic [tccw_pkg::COL_W-1:0]    req_column     = '0;
   logic [tccw_pkg::COLOR_W-1:0]  req_foreground = '0;
   logic [tccw_pkg::COLOR_W-1:0]  req_background = '0;
   logic                          csr_valid      = 1'b0;
   logic                          csr_ready;
   logic [tccw_pkg::ATTR_W-1:0]   csr_wdata      = '0;
   logic                          rsp_valid;
   logic [tccw_pkg::CELL_W-1:0]   rsp_cell_value;
   logic [tccw_pkg::ROW_W-1:0]    rsp_cursor_row_out;
   logic [tccw_pkg::COL_W-1:0]    rsp_cursor_column_out;
   logic [tccw_pkg::POS_W-1:0]    rsp_cursor_position;
   int                            fail_count;
   int                            open_count;

   int idle_pct   = 0;
   int burst_left = 0;

   text_console_character_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_character         (req_character),
      .req_row               (req_row),
      .req_column            (req_column),
      .req_foreground        (req_foreground),
      .req_background        (req_background),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_cell_value        (rsp_cell_value),
      .rsp_cursor_row_out    (rsp_cursor_row_out),
      .rsp_cursor_column_out (rsp_cursor_column_out),
      .rsp_cursor_position   (rsp_cursor_position)
   );

   text_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_character         (req_character),
      .req_row               (req_row),
      .req_column            (req_column),
      .req_foreground        (req_foreground),
      .req_background        (req_background),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_cell_value        (rsp_cell_value),
      .rsp_cursor_row_out    (rsp_cursor_row_out),
      .rsp_cursor_column_out (rsp_cursor_column_out),
      .rsp_cursor_position   (rsp_cursor_position),
      .fail_count            (fail_count),
      .open_count            (open_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_request(
      input logic [tccw_pkg::OP_W-1:0]    op,
      input logic [tccw_pkg::CHAR_W-1:0]  ch,
      input logic [tccw_pkg::ROW_W-1:0]   row,
      input logic [tccw_pkg::COL_W-1:0]   col,
      input logic [tccw_pkg::COLOR_W-1:0] fg,
      input logic [tccw_pkg::COLOR_W-1:0] bg
   );
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_operation  <= op;
      req_character  <= ch;
      req_row        <= row;
      req_column     <= col;
      req_foreground <= fg;
      req_background <= bg;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_text_color(input logic [tccw_pkg::ATTR_W-1:0] color);
      bit taken;
      drain_responses();
      csr_valid <= 1'b1;
      csr_wdata <= color;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [tccw_pkg::CHAR_W-1:0] pick_stream_char();
      int sel;
      sel = $urandom_range(99);
      if (sel < 5) return tccw_pkg::CHAR_NEWLINE;
      if (sel < 9) return tccw_pkg::CHAR_RETURN;
      if (sel < 15) return tccw_pkg::CHAR_BACKSPACE;
      if (sel < 21) return tccw_pkg::CHAR_TAB;
      return tccw_pkg::CHAR_W'($urandom_range(255));
   endfunction

   task automatic pick_location(output logic [tccw_pkg::ROW_W-1:0] row,
                                output logic [tccw_pkg::COL_W-1:0] col);
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) begin
         row = tccw_pkg::ROW_W'($urandom_range(2));
         col = tccw_pkg::COL_W'($urandom_range(15));
      end else if (sel < 80) begin
         row = tccw_pkg::ROW_W'($urandom_range(ROWS - 1));
         col = tccw_pkg::COL_W'($urandom_range(COLUMNS - 1));
      end else begin
         row = tccw_pkg::ROW_W'($urandom_range(31));
         col = tccw_pkg::COL_W'($urandom_range(127));
      end
   endtask

   task automatic send_random_request();
      logic [tccw_pkg::OP_W-1:0]    op;
      logic [tccw_pkg::CHAR_W-1:0]  ch;
      logic [tccw_pkg::ROW_W-1:0]   row;
      logic [tccw_pkg::COL_W-1:0]   col;
      int                           sel;
      op  = tccw_pkg::OP_STREAM;
      ch  = tccw_pkg::CHAR_W'($urandom_range(255));
      row = tccw_pkg::ROW_W'($urandom_range(31));
      col = tccw_pkg::COL_W'($urandom_range(127));
      sel = $urandom_range(99);
      if (burst_left > 0) begin
         burst_left--;
         ch = pick_stream_char();
      end else if (sel < 40) begin
         ch = pick_stream_char();
      end else if (sel < 55) begin
         op = tccw_pkg::OP_WRITE;
         pick_location(row, col);
      end else if (sel < 70) begin
         op = tccw_pkg::OP_READ;
         pick_location(row, col);
      end else if (sel < 82) begin
         op  = tccw_pkg::OP_CURSOR;
         sel = $urandom_range(99);
         if (sel < 30) row = tccw_pkg::ROW_W'($urandom_range(2));
         else if (sel < 60) row = tccw_pkg::ROW_W'($urandom_range(ROWS - 1));
         else if (sel < 80) row = tccw_pkg::ROW_W'($urandom_range(ROWS - 1, ROWS - 3));
         sel = $urandom_range(99);
         if (sel < 40) col = tccw_pkg::COL_W'($urandom_range(15));
         else if (sel < 70) col = tccw_pkg::COL_W'($urandom_range(COLUMNS - 1));
         else if (sel < 85) col = tccw_pkg::COL_W'($urandom_range(COLUMNS - 1, COLUMNS - 10));
      end else if (sel < 84) begin
         op = tccw_pkg::OP_CLEAR;
      end else if (sel < 90) begin
         op = tccw_pkg::OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end else begin
         burst_left = $urandom_range(90, 10);
         ch = pick_stream_char();
      end
      send_request(op, ch, row, col, tccw_pkg::COLOR_W'($urandom_range(15)),
                   tccw_pkg::COLOR_W'($urandom_range(15)));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      send_request(tccw_pkg::OP_READ,   8'h00, 5'd0,  7'd0,   4'd0,  4'd0);
      send_request(tccw_pkg::OP_READ,   8'hFF, 5'd31, 7'd127, 4'd15, 4'd15);
      send_request(tccw_pkg::OP_WRITE,  8'hFF, 5'd0,  7'd0,   4'd15, 4'd15);
      send_request(tccw_pkg::OP_WRITE,  8'h00, 5'd0,  7'd1,   4'd0,  4'd0);
      send_request(tccw_pkg::OP_WRITE,  8'h5A, 5'd25, 7'd0,   4'd3,  4'd12);
      send_request(tccw_pkg::OP_WRITE,  8'hA5, 5'd0,  7'd80,  4'd12, 4'd3);
      send_request(tccw_pkg::OP_READ,   8'h00, 5'd0,  7'd0,   4'd0,  4'd0);
      send_request(tccw_pkg::OP_READ,   8'h00, 5'd0,  7'd1,   4'd0,  4'd0);
      send_request(tccw_pkg::OP_READ,   8'h00, 5'd24, 7'd79,  4'd0,  4'd0);
      send_request(tccw_pkg::OP_READ,   8'h00, 5'd0,  7'd80,  4'd0,  4'd0);
      send_request(tccw_pkg::OP_STREAM, 8'h41, 5'd0,  7'd0,   4'd0,  4'd0);
      send_request(tccw_pkg::OP_STREAM, tccw_pkg::CHAR_TAB,       5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tccw_pkg::OP_STREAM, tccw_pkg::CHAR_BACKSPACE, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tccw_pkg::OP_STREAM, tccw_pkg::CHAR_RETURN,    5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tccw_pkg::OP_STREAM, tccw_pkg::CHAR_BACKSPACE, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tccw_pkg::OP_CURSOR, 8'h00, 5'd31, 7'd127, 4'd0,  4'd0);
      send_request(tccw_pkg::OP_STREAM, 8'h7E, 5'd0,  7'd0,   4'd0,  4'd0);
      send_request(tccw_pkg::OP_CURSOR, 8'h00, 5'd24, 7'd75,  4'd0,  4'd0);
      send_request(tccw_pkg::OP_STREAM, tccw_pkg::CHAR_TAB,     5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tccw_pkg::OP_STREAM, tccw_pkg::CHAR_NEWLINE, 5'd0, 7'd0, 4'd0, 4'd0);
      send_request(tccw_pkg::OP_READ,   8'h00, 5'd22, 7'd79,  4'd0,  4'd0);
      send_request(OP_SPARE_FIRST, 8'h33, 5'd3, 7'd3, 4'd3, 4'd3);
      send_request(OP_SPARE_LAST,  8'hCC, 5'd31, 7'd127, 4'd15, 4'd15);
      send_request(tccw_pkg::OP_CLEAR,  8'h00, 5'd0,  7'd0,   4'd0,  4'd0);
      send_request(tccw_pkg::OP_READ,   8'h00, 5'd0,  7'd0,   4'd0,  4'd0);

      write_text_color(8'hFF);
      idle_pct = 0;
      repeat (PHASE_ITEMS) send_random_request();

      write_text_color(8'h00);
      idle_pct = 69;
      repeat (PHASE_ITEMS) send_random_request();

      write_text_color(tccw_pkg::ATTR_W'($urandom_range(255)));
      idle_pct = 13;
      repeat (PHASE_ITEMS / 2) send_random_request();
      drain_responses();
      repeat (PHASE_ITEMS / 2) send_random_request();

      write_text_color(tccw_pkg::ATTR_W'($urandom_range(255)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: idle_pct = 0;
               1: idle_pct = 69;
               default: idle_pct = 13;
            endcase
         end
         send_random_request();
      end

      drain_responses();
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/tccw_pkg.sv
rtl/tccw_ctrl.sv
rtl/tccw_datapath.sv
rtl/text_console_character_writer.sv
dv/text_console_checker.sv
dv/tb_text_console_character_writer.sv
